// ----- rtl/tlik_pkg.sv -----
// ----------------------------------------------------------------------------
// tlik_pkg
// Types and constants shared by the two-link planar inverse kinematics block.
// ----------------------------------------------------------------------------
package tlik_pkg;

  localparam int CordicSteps = 23;
  localparam int StepW       = 5;
  localparam int CordW       = 56;
  localparam int ZW          = 26;

  localparam logic signed [15:0] Deg90Q6  = 16'sd5760;
  localparam logic signed [15:0] Deg150Q6 = 16'sd9600;
  localparam logic signed [ZW-1:0] Deg180Q16 = 26'sd11796480;
  localparam logic signed [CordW-1:0] NormFloor = 56'sd35184372088832;
  localparam logic [31:0] OneQ30 = 32'd1073741824;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_ELB_LOAD,
    ST_NORM,
    ST_ITER,
    ST_ELB_DONE,
    ST_TAN_MUL,
    ST_TAN_SUM,
    ST_SHD_DONE,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul;
    logic div_start;
    logic div_step;
    logic sqrt_start;
    logic sqrt_step;
    logic elb_load;
    logic norm;
    logic iter;
    logic elb_done;
    logic tan_mul;
    logic tan_sum;
    logic shd_done;
    logic fail;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reach;
    logic last_step;
    logic norm_ok;
    logic tx_zero;
  } stat_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [StepW-1:0] i);
    logic signed [ZW-1:0] v;
    v = '0;
    case (i)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/two_link_planar_ik.sv -----
// ----------------------------------------------------------------------------
// two_link_planar_ik
// Inverse kinematics for a planar arm with two links of equal length.
// ----------------------------------------------------------------------------
// One target beat is taken at a time. For a reachable target the result beat
// is formed by the squares, a divider for the elbow cosine (a load plus 31
// quotient bits), a square root (a load plus 31 steps), then two passes of
// one shared 23-step CORDIC unit (elbow and shoulder). Each pass is preceded
// by a normalizing shift of one bit per cycle until a check sees that it is
// done; the elbow needs at most 16 shifts, the shoulder up to 45 when the
// tangent vector is tiny. Between the passes ST_ELB_DONE registers the elbow
// angle and ST_TAN_MUL and ST_TAN_SUM form the shoulder tangents; ST_SHD_DONE
// after the last pass registers the angle. An unreachable target skips the
// square root and the CORDIC passes and gives its result beat with the held
// shoulder angle. The result beat stays until the output side takes it, and
// the next target can be taken in the cycle after; the link length register
// may be written only while the block is idle.
module two_link_planar_ik (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [13:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_shoulder_deg,
  output logic signed [15:0] out_elbow_deg,
  output logic               out_reachable
);
  import tlik_pkg::*;

  logic [13:0] link_length_r;
  cmd_t  cmd;
  stat_t stat;

  // Link length register, reset to about 3.9 in Q4.10.
  always_ff @(posedge clk) begin
    if (!rst_n) link_length_r <= 14'd3994;
    else if (cfg_we) link_length_r <= cfg_wdata;
  end

  tlik_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  tlik_dp u_dp (
    .clk(clk), .rst_n(rst_n), .link_len(link_length_r),
    .tx_in(in_target_x), .ty_in(in_target_y), .cmd(cmd), .stat(stat),
    .shoulder(out_shoulder_deg), .elbow(out_elbow_deg), .reach(out_reachable)
  );

endmodule

// ----- rtl/tlik_ctrl.sv -----
// ----------------------------------------------------------------------------
// tlik_ctrl
// Sequencer that steps the datapath through one target at a time.
// ----------------------------------------------------------------------------
module tlik_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  tlik_pkg::stat_t stat,
  output tlik_pkg::cmd_t  cmd
);
  import tlik_pkg::*;

  state_t state_r, state_nxt;
  logic   elbow_r, elbow_nxt;
  logic [6:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      elbow_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      elbow_r <= elbow_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    elbow_nxt = elbow_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_DIV;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        if (!stat.reach) begin
          cmd.fail = 1'b1;
          state_nxt = ST_OUT;
        end else if (cnt_r == 7'd0) begin
          cmd.div_start = 1'b1;
          cnt_nxt = 7'd1;
        end else begin
          cmd.div_step = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd31) begin
            state_nxt = ST_SQRT;
            cnt_nxt = '0;
          end
        end
      end
      ST_SQRT: begin
        if (cnt_r == 7'd0) begin
          cmd.sqrt_start = 1'b1;
          cnt_nxt = 7'd1;
        end else begin
          cmd.sqrt_step = 1'b1;
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd31) state_nxt = ST_ELB_LOAD;
        end
      end
      ST_ELB_LOAD: begin
        cmd.elb_load = 1'b1;
        elbow_nxt = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (stat.norm_ok) state_nxt = ST_ITER;
        else cmd.norm = 1'b1;
      end
      ST_ITER: begin
        cmd.iter = 1'b1;
        if (stat.last_step) state_nxt = elbow_r ? ST_ELB_DONE : ST_SHD_DONE;
      end
      ST_ELB_DONE: begin
        cmd.elb_done = 1'b1;
        elbow_nxt = 1'b0;
        state_nxt = ST_TAN_MUL;
      end
      ST_TAN_MUL: begin
        cmd.tan_mul = 1'b1;
        state_nxt = ST_TAN_SUM;
      end
      ST_TAN_SUM: begin
        cmd.tan_sum = 1'b1;
        state_nxt = ST_NORM;
      end
      ST_SHD_DONE: begin
        cmd.shd_done = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/tlik_dp.sv -----
// ----------------------------------------------------------------------------
// tlik_dp
// Arithmetic for the block: squares, a restoring divider, a square root,
// and one shared CORDIC vectoring unit.
// ----------------------------------------------------------------------------
module tlik_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [13:0]         link_len,
  input  logic signed [15:0]  tx_in,
  input  logic signed [15:0]  ty_in,
  input  tlik_pkg::cmd_t      cmd,
  output tlik_pkg::stat_t     stat,
  output logic signed [15:0]  shoulder,
  output logic signed [15:0]  elbow,
  output logic                reach
);
  import tlik_pkg::*;

  logic signed [15:0] x_r, y_r;
  logic [13:0] len_r;
  logic [32:0] r2_r;
  logic [28:0] den_r;
  logic        neg_r;
  logic        reach_r;
  // Divider: quotient of (mag << 30 + den/2) / den, one bit a cycle.
  // The quotient fits in 31 bits, so the top of the dividend seeds the
  // remainder and only the low 31 bits are shifted through.
  logic [59:0] dnum_r;
  logic [31:0] quo_r;
  logic [29:0] rem_r;
  // Square root.
  logic [61:0] sv_r;
  logic [61:0] sres_r;
  logic [61:0] sbit_r;
  logic signed [31:0] c_r;
  // CORDIC.
  logic signed [CordW-1:0] cx_r, cy_r;
  logic signed [ZW-1:0] cz_r;
  logic [StepW-1:0] step_r;
  logic zero_r;
  logic flip_r;
  // Shoulder products.
  logic signed [49:0] p0_r, p1_r, p2_r, p3_r;
  logic signed [15:0] shd_r, elb_r, held_r;

  logic        lt;
  logic [29:0] mag;
  logic [59:0] dval;
  logic [30:0] rtry;
  logic [62:0] sacc;
  logic signed [CordW-1:0] ay, xs, ys;
  logic signed [51:0] txs, tys;
  logic signed [ZW-1:0] zr;
  logic signed [16:0] esat;
  logic signed [32:0] a_q30;
  logic signed [31:0] s_q30;

  assign lt    = r2_r < 33'(den_r);
  assign mag   = lt ? 30'(33'(den_r) - r2_r) : 30'(r2_r - 33'(den_r));
  assign dval  = {mag, 30'd0} + 60'(den_r[28:1]);
  assign rtry  = {rem_r, dnum_r[59]};
  assign ay    = cy_r[CordW-1] ? -cy_r : cy_r;
  assign xs    = cx_r >>> step_r;
  assign ys    = cy_r >>> step_r;
  assign a_q30 = $signed({1'b0, OneQ30}) + 33'(c_r);
  assign s_q30 = $signed({1'b0, sres_r[30:0]});
  assign txs   = 52'(p0_r) + 52'(p3_r);
  assign tys   = 52'(p2_r) - 52'(p1_r);
  assign zr    = (cz_r + 26'sd512) >>> 10;

  always_comb begin
    sacc = 63'(sres_r) + 63'(sbit_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      reach_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        x_r   <= tx_in;
        y_r   <= ty_in;
        len_r <= link_len;
      end
      if (cmd.mul) begin
        r2_r    <= 33'(32'(x_r) * 32'(x_r)) + 33'(32'(y_r) * 32'(y_r));
        den_r   <= {28'(len_r) * 28'(len_r), 1'b0};
        reach_r <= 1'b1;
      end
      if (cmd.div_start) begin
        reach_r <= (len_r != 14'd0) && ({1'b0, r2_r} <= {den_r, 1'b0} + 34'd0);
        neg_r   <= lt;
        dnum_r  <= dval << 29;
        rem_r   <= 30'(dval[59:31]);
        quo_r   <= '0;
      end
      if (cmd.div_step) begin
        dnum_r <= dnum_r << 1;
        if (rtry >= 31'(den_r)) begin
          rem_r <= 30'(rtry - 31'(den_r));
          quo_r <= {quo_r[30:0], 1'b1};
        end else begin
          rem_r <= rtry[29:0];
          quo_r <= {quo_r[30:0], 1'b0};
        end
      end
      if (cmd.sqrt_start) begin
        c_r    <= neg_r ? -$signed(quo_r[31:0]) : $signed(quo_r[31:0]);
        sv_r   <= 62'(64'd1 << 60) - 62'(quo_r[31:0] * quo_r[31:0]);
        sres_r <= '0;
        sbit_r <= 62'(64'd1 << 60);
      end
      if (cmd.sqrt_step) begin
        if (sbit_r != '0) begin
          if (63'(sv_r) >= sacc) begin
            sv_r   <= 62'(63'(sv_r) - sacc);
            sres_r <= 62'((63'(sres_r) >> 1) + 63'(sbit_r));
          end else begin
            sres_r <= sres_r >> 1;
          end
          sbit_r <= sbit_r >> 2;
        end
      end
      if (cmd.elb_load) begin
        cx_r   <= CordW'(c_r[31] ? -c_r : c_r);
        cy_r   <= CordW'(s_q30);
        cz_r   <= '0;
        step_r <= '0;
        zero_r <= 1'b0;
        flip_r <= c_r[31];
      end
      if (cmd.norm) begin
        if (cx_r == '0 && cy_r == '0) zero_r <= 1'b1;
        cx_r <= cx_r <<< 1;
        cy_r <= cy_r <<< 1;
      end
      if (cmd.iter) begin
        step_r <= step_r + 5'd1;
        if (cy_r > 0) begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + atan_q16(step_r);
        end else begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - atan_q16(step_r);
        end
      end
      if (cmd.elb_done) begin
        elb_r <= 16'((flip_r ? Deg180Q16 - cz_r + 26'sd512 : cz_r + 26'sd512) >>> 10);
      end
      if (cmd.tan_mul) begin
        p0_r <= 50'(x_r) * 50'(a_q30);
        p1_r <= 50'(x_r) * 50'(s_q30);
        p2_r <= 50'(y_r) * 50'(a_q30);
        p3_r <= 50'(y_r) * 50'(s_q30);
      end
      if (cmd.tan_sum) begin
        cx_r   <= txs[51] ? CordW'(-txs) : CordW'(txs);
        cy_r   <= txs[51] ? CordW'(-tys) : CordW'(tys);
        cz_r   <= '0;
        step_r <= '0;
        zero_r <= (txs == '0);
        flip_r <= tys[51] ? 1'b1 : 1'b0;
        p0_r   <= 50'(tys != '0);
      end
      if (cmd.shd_done) begin
        if (zero_r) shd_r <= (p0_r[0] == 1'b0) ? 16'sd0 : (flip_r ? -Deg90Q6 : Deg90Q6);
        else shd_r <= 16'(zr);
        held_r <= (zero_r) ? ((p0_r[0] == 1'b0) ? 16'sd0 : (flip_r ? -Deg90Q6 : Deg90Q6))
                           : 16'(zr);
      end
      if (cmd.fail) begin
        shd_r <= held_r;
        elb_r <= (esat < -17'sd32768) ? -16'sd32768 : 16'(esat);
      end
    end
  end

  assign esat = 17'(held_r) - 17'(Deg150Q6);

  always_comb begin
    stat.reach     = reach_r;
    stat.last_step = (step_r == 5'(CordicSteps - 1));
    stat.norm_ok   = zero_r || (cx_r >= NormFloor) || (ay >= NormFloor);
    stat.tx_zero   = zero_r;
  end

  assign shoulder = shd_r;
  assign elbow    = elb_r;
  assign reach    = reach_r;

endmodule

// ----- rtl/tlik_checker.sv -----
// ----------------------------------------------------------------------------
// tlik_checker
// Port-level checks for the inverse kinematics block.
// ----------------------------------------------------------------------------
module tlik_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_shoulder_deg
);
  // Only one beat is in flight: no input is taken while a result waits.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during result");
  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shoulder_deg))
    else $error("result dropped");
  // An accepted beat leaves the input stalled next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second beat taken");
endmodule

bind two_link_planar_ik tlik_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_shoulder_deg(out_shoulder_deg)
);
